### rtl/core/rrbd_pkg.sv
package rrbd_pkg;

    // field widths
    localparam int CNT_W   = 32;
    localparam int BURST_W = 16;
    localparam int IDX_W   = 3;
    localparam int WCNT_W  = 4;

    // stream packing
    localparam int S_TDATA_W = 2 * BURST_W;
    localparam int M_FIELD_W = IDX_W + BURST_W + CNT_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    // command codes carried on the slave tuser bit
    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic update;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_deq;
        logic found;
        logic last_step;
        logic out_free;
    } t_status;

endpackage

### rtl/core/rrbd_ctrl.sv
module rrbd_ctrl
    import rrbd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_status.in_deq ? ST_SCAN : ST_UPDATE;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.found || i_status.last_step) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (i_status.out_free) begin
                    o_cmd.update = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/rrbd_dpath.sv
module rrbd_dpath
    import rrbd_pkg::*;
#(
    parameter int MAX_WORKERS = 8
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [WCNT_W-1:0]    i_cfg_wdata,
    input  logic                 i_in_deq,
    input  logic [S_TDATA_W-1:0] i_in_data,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [M_TDATA_W-1:0] o_out_data,
    output logic                 o_out_none
);

    localparam int PW = $clog2(MAX_WORKERS);

    logic [CNT_W-1:0]   r_cnt [MAX_WORKERS];
    logic [PW-1:0]      r_enq_ptr;
    logic [PW-1:0]      r_deq_ptr;
    logic [PW-1:0]      r_last;
    logic [PW-1:0]      r_sel;
    logic [PW-1:0]      r_steps;
    logic               r_deq;
    logic               r_none;
    logic               r_burst_nz;
    logic [BURST_W-1:0] r_taken;
    logic               r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;
    logic               r_out_none;

    logic [BURST_W-1:0] in_burst;
    logic [BURST_W-1:0] in_done;
    logic [PW-1:0]      cfg_last;
    logic [PW-1:0]      sel_next;
    logic [CNT_W-1:0]   cur;
    logic [CNT_W:0]     sum;
    logic [CNT_W:0]     diff;
    logic [CNT_W-1:0]   new_cnt;
    logic [BURST_W-1:0] res_taken;
    logic [CNT_W-1:0]   res_after;
    logic [31:0]        sel_ext;

    assign in_burst = i_in_data[BURST_W-1:0];
    assign in_done  = i_in_data[2*BURST_W-1:BURST_W];

    // last valid worker index from the written worker count
    always_comb begin
        if (i_cfg_wdata == '0) begin
            cfg_last = '0;
        end else if (32'(i_cfg_wdata) > MAX_WORKERS) begin
            cfg_last = PW'(MAX_WORKERS - 1);
        end else begin
            cfg_last = PW'(i_cfg_wdata - 1'b1);
        end
    end

    // rotation step with wrap
    assign sel_next = (r_sel == r_last) ? '0 : r_sel + 1'b1;

    // counter of the selected worker and its updates
    assign cur  = r_cnt[r_sel];
    assign sum  = {1'b0, cur} + {{(CNT_W + 1 - BURST_W){1'b0}}, r_taken};
    assign diff = {1'b0, cur} - {{(CNT_W + 1 - BURST_W){1'b0}}, r_taken};

    always_comb begin
        if (!r_deq) begin
            new_cnt   = sum[CNT_W] ? '1 : sum[CNT_W-1:0];
            res_taken = r_taken;
            res_after = new_cnt;
        end else if (r_none) begin
            new_cnt   = cur;
            res_taken = '0;
            res_after = '0;
        end else if (diff[CNT_W]) begin
            // clamp at zero, the whole counter is taken
            new_cnt   = '0;
            res_taken = cur[BURST_W-1:0];
            res_after = '0;
        end else begin
            new_cnt   = diff[CNT_W-1:0];
            res_taken = r_taken;
            res_after = new_cnt;
        end
    end

    assign sel_ext = 32'(r_sel);

    // status to controller
    assign o_status.in_deq    = i_in_deq;
    assign o_status.found     = (cur != '0);
    assign o_status.last_step = (r_steps == r_last);
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    // counters, pointers and worker count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_WORKERS; i++) begin
                r_cnt[i] <= '0;
            end
            r_enq_ptr <= '0;
            r_deq_ptr <= '0;
            r_last    <= '0;
        end else if (i_cfg_we) begin
            for (int i = 0; i < MAX_WORKERS; i++) begin
                r_cnt[i] <= '0;
            end
            r_enq_ptr <= '0;
            r_deq_ptr <= '0;
            r_last    <= cfg_last;
        end else if (i_cmd.update) begin
            if (!r_deq) begin
                r_cnt[r_sel] <= new_cnt;
                if (r_burst_nz) begin
                    r_enq_ptr <= sel_next;
                end
            end else if (!r_none) begin
                r_cnt[r_sel] <= new_cnt;
                r_deq_ptr    <= sel_next;
            end
        end
    end

    // per-transaction working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_deq      <= i_in_deq;
            r_sel      <= (i_in_deq == CMD_DEQ) ? r_deq_ptr : r_enq_ptr;
            r_steps    <= '0;
            r_none     <= 1'b0;
            r_burst_nz <= (in_burst != '0);
            r_taken    <= (in_done < in_burst) ? in_done : in_burst;
        end else if (i_cmd.scan && (cur == '0)) begin
            if (r_steps == r_last) begin
                r_none <= 1'b1;
                r_sel  <= r_deq_ptr;
            end else begin
                r_sel   <= sel_next;
                r_steps <= r_steps + 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.update) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_out_data <= M_TDATA_W'({res_after, res_taken, sel_ext[IDX_W-1:0]});
            r_out_none <= r_deq && r_none;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_none  = r_out_none;

endmodule

### rtl/core/round_robin_burst_dispatcher_unit.sv
// enqueue: the transaction is loaded in idle, then the counter is updated and the
// result registered in the update state, which waits until the output register is free;
// dequeue: a scan state first searches one worker per cycle for a nonzero counter
// throughput: one transaction at a time, a new one is taken only back in idle
// reset: synchronous active-low; counters and pointers clear, worker count is 1
module round_robin_burst_dispatcher_unit
    import rrbd_pkg::*;
#(
    parameter int MAX_WORKERS = 8
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [WCNT_W-1:0]    i_cfg_wdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // burst_size[15:0], done_count[31:16]
    input  logic                 s_axis_tuser,  // command
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // worker_index[2:0], count_taken[18:3], in_flight_after[50:19], zero pad
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    output logic                 m_axis_tuser   // none_in_flight
);

    t_cmd    cmd;
    t_status status;

    // sequencer
    rrbd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_status   (status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    // counters, pointers and result register
    rrbd_dpath #(
        .MAX_WORKERS (MAX_WORKERS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_deq    (s_axis_tuser),
        .i_in_data   (s_axis_tdata),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_none  (m_axis_tuser)
    );

endmodule

### rtl/core/rrbd_checker.sv
module rrbd_checker
    import rrbd_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic                 m_axis_tuser
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // an empty dequeue reports nothing taken and nothing in flight
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
            m_axis_tdata[IDX_W+BURST_W+CNT_W-1:IDX_W] == '0)
        else $error("empty dequeue with nonzero counts");

    // one transaction at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a transaction is in work");

    // a new result only comes out of work in progress
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared without a transaction in work");

endmodule

bind round_robin_burst_dispatcher_unit rrbd_checker u_rrbd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
